@@ sv/snoc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snoc_pkg
// Shared constants, codes and widths for the sender nonce order checker.
// ----------------------------------------------------------------------------
package snoc_pkg;
   localparam int MaxWallets = 1024;
   localparam int MaxSenders = 1024;
   localparam int WalletIdxW = $clog2(MaxWallets);
   localparam int SenderIdxW = $clog2(MaxSenders);
   localparam int WalletCntW = $clog2(MaxWallets + 1);
   localparam int SenderCntW = $clog2(MaxSenders + 1);
   localparam int KeyW = 256;
   localparam int WordW = 64;
   localparam int CountW = 16;
   localparam logic [CountW-1:0] CountMax = '1;

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_BATCH  = 2'd2,
      FUNC_CHECK  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOWALLET = 3'd1,
      ST_NONCE    = 3'd2,
      ST_FUNDS    = 3'd3,
      ST_FULL     = 3'd4
   } status_type;
endpackage

@@ sv/snoc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snoc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module snoc_ram #(
   parameter int Width = 64,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ sv/sender_nonce_order_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sender_nonce_order_checker
// Wallet table with per-batch sender nonce tracking and balance checks.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req_    | in  | tuser func; tdata key_word0..3, nonce, amount
//  rsp_    | out | tdata status, exp_nonce, ok_count, fail_count
//
//  Check: scans the wallet keys, then the seen-sender keys, one entry at a time,
//  through the single read port of the key memories. Other functions go
//  straight to the output state. Reset clears counts and control state; the
//  memories need no clearing. One item at a time; a new item is taken once the
//  previous result has left the output register.
// ----------------------------------------------------------------------------
module sender_nonce_order_checker
   import snoc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [383:0] req_tdata,   // key_word0..3, nonce, amount
   input  logic [1:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata    // status, exp_nonce, ok_count, fail_count
);
   typedef enum logic [2:0] {
      S_IDLE, S_WSCAN, S_WLOAD, S_SSCAN, S_DECIDE, S_OUT
   } state_type;

   state_type            state_ff;
   logic [KeyW-1:0]      key_ff;
   logic [WordW-1:0]     nonce_ff, amount_ff, exp_ff;
   logic [WalletCntW-1:0] wcnt_ff;
   logic [SenderCntW-1:0] scnt_ff;
   logic [CountW-1:0]    okc_ff, failc_ff;
   logic [WalletCntW-1:0] widx_ff;
   logic [SenderCntW-1:0] sidx_ff;
   logic                 rdv_ff, sfound_ff;
   logic [2:0]           status_ff;
   logic                 rsp_valid_ff;

   logic                 wk_we, sk_we, wn_we, sn_we;
   logic [WalletIdxW-1:0] wk_addr, wn_addr;
   logic [SenderIdxW-1:0] sk_addr, sn_addr;
   logic [KeyW-1:0]      wk_rd, sk_rd;
   logic [WordW-1:0]     wn_rd, wb_rd, sn_rd;
   logic [WordW-1:0]     sn_wdata;
   logic [WordW-1:0]     exp_sel;
   logic                 dec_go, dec_pass;

   snoc_ram #(.Width(KeyW), .Depth(MaxWallets)) u_wkey (
      .clock(clock), .wr_en(wk_we), .addr(wk_addr), .wr_data(req_tdata[255:0]),
      .rd_data(wk_rd));
   snoc_ram #(.Width(WordW), .Depth(MaxWallets)) u_wnonce (
      .clock(clock), .wr_en(wn_we), .addr(wn_addr), .wr_data(req_tdata[319:256]),
      .rd_data(wn_rd));
   snoc_ram #(.Width(WordW), .Depth(MaxWallets)) u_wbal (
      .clock(clock), .wr_en(wn_we), .addr(wn_addr), .wr_data(req_tdata[383:320]),
      .rd_data(wb_rd));
   snoc_ram #(.Width(KeyW), .Depth(MaxSenders)) u_skey (
      .clock(clock), .wr_en(sk_we), .addr(sk_addr), .wr_data(key_ff),
      .rd_data(sk_rd));
   snoc_ram #(.Width(WordW), .Depth(MaxSenders)) u_snonce (
      .clock(clock), .wr_en(sn_we), .addr(sn_addr), .wr_data(sn_wdata),
      .rd_data(sn_rd));

   logic req_fire, wfull;
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign wfull      = (wcnt_ff == WalletCntW'(MaxWallets));
   assign dec_go     = (state_ff == S_DECIDE) && (!sfound_ff || rdv_ff);
   assign exp_sel    = sfound_ff ? sn_rd : exp_ff;
   assign dec_pass   = dec_go && nonce_ff == exp_sel && wb_rd >= amount_ff;
   assign sn_wdata   = exp_sel + 64'd1;

   always_comb begin
      wk_we   = 1'b0;
      wn_we   = 1'b0;
      sk_we   = 1'b0;
      sn_we   = 1'b0;
      wk_addr = widx_ff[WalletIdxW-1:0];
      wn_addr = widx_ff[WalletIdxW-1:0];
      sk_addr = sidx_ff[SenderIdxW-1:0];
      sn_addr = sidx_ff[SenderIdxW-1:0];
      if (req_fire && func_type'(req_tuser) == FUNC_APPEND && !wfull) begin
         wk_we   = 1'b1;
         wn_we   = 1'b1;
         wk_addr = wcnt_ff[WalletIdxW-1:0];
         wn_addr = wcnt_ff[WalletIdxW-1:0];
      end
      if (dec_pass) begin
         if (sfound_ff) begin
            sn_we = 1'b1;
         end else if (scnt_ff != SenderCntW'(MaxSenders)) begin
            sk_we   = 1'b1;
            sn_we   = 1'b1;
            sk_addr = scnt_ff[SenderIdxW-1:0];
            sn_addr = scnt_ff[SenderIdxW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wcnt_ff      <= '0;
         scnt_ff      <= '0;
         okc_ff       <= '0;
         failc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rdv_ff       <= 1'b0;
         sfound_ff    <= 1'b0;
         widx_ff      <= '0;
         sidx_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  key_ff    <= req_tdata[255:0];
                  nonce_ff  <= req_tdata[319:256];
                  amount_ff <= req_tdata[383:320];
                  exp_ff    <= '0;
                  status_ff <= (func_type'(req_tuser) == FUNC_APPEND && wfull) ?
                               ST_FULL : ST_OK;
                  widx_ff   <= '0;
                  sidx_ff   <= '0;
                  rdv_ff    <= 1'b0;
                  sfound_ff <= 1'b0;
                  state_ff  <= (func_type'(req_tuser) == FUNC_CHECK) ? S_WSCAN : S_OUT;
                  unique case (func_type'(req_tuser))
                     FUNC_CLEAR: wcnt_ff <= '0;
                     FUNC_APPEND: begin
                        if (!wfull) wcnt_ff <= wcnt_ff + 1'b1;
                     end
                     FUNC_BATCH: begin
                        scnt_ff  <= '0;
                        okc_ff   <= '0;
                        failc_ff <= '0;
                     end
                     FUNC_CHECK: ;
                     default: ;
                  endcase
               end
            end
            S_WSCAN: begin
               // widx_ff is address in flight; rdv_ff marks data of widx_ff-1
               if (rdv_ff && wk_rd == key_ff) begin
                  widx_ff  <= widx_ff - 1'b1;
                  rdv_ff   <= 1'b0;
                  state_ff <= S_WLOAD;
               end else if (widx_ff >= wcnt_ff) begin
                  status_ff <= ST_NOWALLET;
                  if (failc_ff != CountMax) failc_ff <= failc_ff + 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  widx_ff <= widx_ff + 1'b1;
                  rdv_ff  <= 1'b1;
               end
            end
            S_WLOAD: begin
               // wallet nonce/balance now reading at the match index
               if (rdv_ff) begin
                  exp_ff   <= wn_rd;
                  state_ff <= S_SSCAN;
               end
               rdv_ff <= 1'b1;
            end
            S_SSCAN: begin
               if (rdv_ff && sidx_ff != '0 && sk_rd == key_ff) begin
                  sidx_ff   <= sidx_ff - 1'b1;
                  sfound_ff <= 1'b1;
                  rdv_ff    <= 1'b0;
                  state_ff  <= S_DECIDE;
               end else if (sidx_ff >= scnt_ff) begin
                  rdv_ff   <= 1'b0;
                  state_ff <= S_DECIDE;
               end else begin
                  sidx_ff <= sidx_ff + 1'b1;
                  rdv_ff  <= 1'b1;
               end
            end
            S_DECIDE: begin
               // wallet balance still on wb_rd; seen nonce on sn_rd once read
               if (!dec_go) begin
                  rdv_ff <= 1'b1;
               end else begin
                  exp_ff   <= exp_sel;
                  state_ff <= S_OUT;
                  if (nonce_ff != exp_sel) begin
                     status_ff <= ST_NONCE;
                     if (failc_ff != CountMax) failc_ff <= failc_ff + 1'b1;
                  end else if (wb_rd < amount_ff) begin
                     status_ff <= ST_FUNDS;
                     if (failc_ff != CountMax) failc_ff <= failc_ff + 1'b1;
                  end else begin
                     if (okc_ff != CountMax) okc_ff <= okc_ff + 1'b1;
                     if (!sfound_ff && scnt_ff != SenderCntW'(MaxSenders)) begin
                        scnt_ff <= scnt_ff + 1'b1;
                     end
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, failc_ff, okc_ff, exp_ff, status_ff};
endmodule

@@ test/sender_nonce_order_checker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sender_nonce_order_checker_test
// Drives wallet loads and clears, batch starts and transaction checks into the
// checker with random idling on both channels and compares every response field
// against an internal model of the wallet and seen-sender tables.
// ----------------------------------------------------------------------------
module sender_nonce_order_checker_test;
   import snoc_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [383:0] req_tdata;   // key_word0..3, nonce, amount
   logic [1:0]   req_tuser;   // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;   // status, exp_nonce, ok_count, fail_count

   typedef struct packed {
      logic [CountW-1:0] fail_count;
      logic [CountW-1:0] ok_count;
      logic [WordW-1:0]  exp_nonce;
      logic [2:0]        status;
   } verdict_type;

   logic [KeyW-1:0]  wallet_keys [MaxWallets];
   logic [WordW-1:0] wallet_nonces [MaxWallets];
   logic [WordW-1:0] wallet_balances [MaxWallets];
   int               wallet_total;
   logic [KeyW-1:0]  seen_keys [MaxSenders];
   logic [WordW-1:0] seen_nonces [MaxSenders];
   int               seen_total;
   logic [CountW-1:0] ok_tally;
   logic [CountW-1:0] fail_tally;

   verdict_type pending_verdicts[$];
   logic     failed;
   logic     quiet;
   logic [KeyW-1:0] key_pool [8];

   sender_nonce_order_checker u_top (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic verdict_type predict_verdict(func_type fn, logic [KeyW-1:0] key,
                                                   logic [WordW-1:0] nonce,
                                                   logic [WordW-1:0] amount);
      verdict_type v;
      int       w;
      int       s;
      v = '0;
      v.status = ST_OK;
      case (fn)
         FUNC_CLEAR: begin
            wallet_total = 0;
         end
         FUNC_APPEND: begin
            if (wallet_total >= MaxWallets) begin
               v.status = ST_FULL;
            end else begin
               wallet_keys[wallet_total] = key;
               wallet_nonces[wallet_total] = nonce;
               wallet_balances[wallet_total] = amount;
               wallet_total++;
            end
         end
         FUNC_BATCH: begin
            seen_total = 0;
            ok_tally = '0;
            fail_tally = '0;
         end
         default: begin
            w = -1;
            s = -1;
            for (int i = wallet_total - 1; i >= 0; i--)
               if (wallet_keys[i] == key) w = i;
            if (w < 0) begin
               v.status = ST_NOWALLET;
               if (fail_tally != CountMax) fail_tally++;
            end else begin
               for (int i = seen_total - 1; i >= 0; i--)
                  if (seen_keys[i] == key) s = i;
               v.exp_nonce = (s >= 0) ? seen_nonces[s] : wallet_nonces[w];
               if (nonce != v.exp_nonce) begin
                  v.status = ST_NONCE;
                  if (fail_tally != CountMax) fail_tally++;
               end else if (wallet_balances[w] < amount) begin
                  v.status = ST_FUNDS;
                  if (fail_tally != CountMax) fail_tally++;
               end else begin
                  if (ok_tally != CountMax) ok_tally++;
                  if (s >= 0) begin
                     seen_nonces[s] = v.exp_nonce + 1'b1;
                  end else if (seen_total < MaxSenders) begin
                     seen_keys[seen_total] = key;
                     seen_nonces[seen_total] = v.exp_nonce + 1'b1;
                     seen_total++;
                  end
               end
            end
         end
      endcase
      v.ok_count = ok_tally;
      v.fail_count = fail_tally;
      return v;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [KeyW-1:0] rand_key();
      return {rand64(), rand64(), rand64(), rand64()};
   endfunction

   task automatic send_item(func_type fn, logic [KeyW-1:0] key, logic [WordW-1:0] nonce,
                            logic [WordW-1:0] amount);
      while (!quiet && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {amount, nonce, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_verdicts.push_back(predict_verdict(fn, key, nonce, amount));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            verdict_type got;
            verdict_type want;
            got = rsp_tdata[98:0];
            if (pending_verdicts.size() == 0) begin
               $error("unexpected transaction %h", rsp_tdata);
               failed = 1'b1;
            end else begin
               want = pending_verdicts.pop_front();
               if (got.status != want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status);
                  failed = 1'b1;
               end
               if (got.exp_nonce != want.exp_nonce) begin
                  $error("exp_nonce exp %h got %h", want.exp_nonce,
                         got.exp_nonce);
                  failed = 1'b1;
               end
               if (got.ok_count != want.ok_count) begin
                  $error("ok_count exp %0d got %0d", want.ok_count, got.ok_count);
                  failed = 1'b1;
               end
               if (got.fail_count != want.fail_count) begin
                  $error("fail_count exp %0d got %0d", want.fail_count, got.fail_count);
                  failed = 1'b1;
               end
            end
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 11);
      end
   end

   task automatic test_directed();
      logic [KeyW-1:0] k;
      k = '1;
      send_item(FUNC_CHECK, k, '0, '0);
      send_item(FUNC_APPEND, k, '1, '1);
      send_item(FUNC_APPEND, '0, '0, '0);
      send_item(FUNC_APPEND, k, 64'd5, 64'd1);
      send_item(FUNC_BATCH, '0, '0, '0);
      send_item(FUNC_CHECK, k, '1, '1);
      send_item(FUNC_CHECK, k, '1, '1);
      send_item(FUNC_CHECK, k, '0, '1);
      send_item(FUNC_CHECK, '0, '0, 64'd1);
      send_item(FUNC_CHECK, '0, '0, '0);
      send_item(FUNC_CHECK, '0, 64'd1, '0);
      send_item(FUNC_CHECK, '0, 64'd7, '0);
      send_item(FUNC_CHECK, rand_key(), rand64(), rand64());
      send_item(FUNC_CLEAR, rand_key(), rand64(), rand64());
      send_item(FUNC_CHECK, k, '0, '0);
      send_item(FUNC_BATCH, rand_key(), rand64(), rand64());
   endtask

   task automatic test_random_batches();
      int idx;
      logic [63:0] n;
      for (int i = 0; i < 8; i++) key_pool[i] = rand_key();
      for (int i = 0; i < 6; i++)
         send_item(FUNC_APPEND, key_pool[i], (i == 0) ? '1 : 64'($urandom_range(3)),
                   64'($urandom_range(1000)));
      for (int b = 0; b < 10; b++) begin
         send_item(FUNC_BATCH, rand_key(), rand64(), rand64());
         for (int t = 0; t < 26; t++) begin
            idx = $urandom_range(7);
            n = (seen_total > 0 && $urandom_range(3) != 0) ?
                seen_nonces[$urandom_range(seen_total - 1)] : 64'($urandom_range(4));
            if ($urandom_range(9) == 0) n = rand64();
            if (idx == 0 && $urandom_range(1)) n = '1;
            send_item(FUNC_CHECK, ($urandom_range(19) == 0) ? rand_key() : key_pool[idx],
                      n, ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(1100)));
         end
         if (b == 3) quiet = 1'b1;
         if (b == 6) quiet = 1'b0;
         if (b == 5) drain();
      end
   endtask

   initial begin
      failed = 1'b0;
      quiet = 1'b0;
      wallet_total = 0;
      seen_total = 0;
      ok_tally = '0;
      fail_tally = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FUNC_CLEAR;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_batches();
      drain();
      if (!failed) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #80ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

@@ sim.f @@
sv/snoc_pkg.sv
sv/snoc_ram.sv
sv/sender_nonce_order_checker.sv
test/sender_nonce_order_checker_test.sv
